// ----- sv/methylation_pair_compare_assert.svh -----
// Assertion macros used by the checker file.
`ifndef METHYLATION_PAIR_COMPARE_ASSERT_SVH
`define METHYLATION_PAIR_COMPARE_ASSERT_SVH

// Clocked implication, disabled during reset.
`define MPC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define MPC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mpc_pkg.sv -----
`default_nettype none
package mpc_pkg;

    localparam int BETA_W    = 17;
    localparam int COUNT_W   = 16;
    localparam int COV_W     = 17;
    localparam int CNT_W     = 29;
    localparam int SUM_W     = 45;
    localparam int SQ_W      = 61;
    localparam int PROD_W    = 2 * BETA_W;
    localparam int DIV_STEPS = BETA_W;

    localparam logic [BETA_W-1:0] BETA_ONE  = 17'h10000;
    localparam logic [CNT_W-1:0]  MAX_SITES = 29'd268435456;

    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef enum logic [2:0] {
        CFG_SUMMARY_MODE = 3'd0,
        CFG_DIRECTION    = 3'd1,
        CFG_COV_FLOOR    = 3'd2,
        CFG_EFFECT_FLOOR = 3'd3,
        CFG_AGREE_THRESH = 3'd4,
        CFG_SIDE_ONE     = 3'd5,
        CFG_SIDE_TWO     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic               summary_mode;
        logic [1:0]         direction;
        logic [16:0]        cov_floor;
        logic signed [17:0] effect_floor;
        logic [16:0]        agree_threshold;
        logic               side_one_is_beta;
        logic               side_two_is_beta;
    } mpc_cfg_t;

    typedef struct packed {
        logic [15:0] meth_one;
        logic [15:0] unmeth_one;
        logic [16:0] beta_one;
        logic        na_one;
        logic [15:0] meth_two;
        logic [15:0] unmeth_two;
        logic [16:0] beta_two;
        logic        na_two;
        logic        last_site;
    } mpc_in_t;

    typedef struct packed {
        logic        in_universe;
        logic        set_bit;
        logic [28:0] count_sites;
        logic [28:0] count_agree;
        logic [44:0] sum_abs_diff;
        logic [60:0] sum_sq_diff;
        logic [44:0] sum_x;
        logic [44:0] sum_y;
        logic [60:0] sum_xx;
        logic [60:0] sum_yy;
        logic [60:0] sum_xy;
        logic        is_last;
    } mpc_out_t;

    // Classified site handed from front to back
    typedef struct packed {
        logic               cov_one;
        logic               cnt_one;
        logic [COUNT_W-1:0] num_one;
        logic [COV_W-1:0]   den_one;
        logic [BETA_W-1:0]  beta_one;
        logic               cov_two;
        logic               cnt_two;
        logic [COUNT_W-1:0] num_two;
        logic [COV_W-1:0]   den_two;
        logic [BETA_W-1:0]  beta_two;
        logic               last;
    } mpc_work_t;

endpackage
`default_nettype wire

// ----- sv/mpc_front.sv -----
`default_nettype none
module mpc_front import mpc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mpc_cfg_t  cfg,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire mpc_in_t   s_data,
    output logic           q_valid,
    output mpc_work_t      q_data,
    input  wire logic      q_pop
);

    mpc_work_t  work;
    mpc_work_t  q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [COV_W-1:0] min_cov;
    logic [COV_W-1:0] cov_one;
    logic [COV_W-1:0] cov_two;
    logic       push;

    // Classify coverage and clamp beta inputs
    always_comb begin
        min_cov = (cfg.cov_floor == '0) ? COV_W'(1) : cfg.cov_floor;
        cov_one = {1'b0, s_data.meth_one} + {1'b0, s_data.unmeth_one};
        cov_two = {1'b0, s_data.meth_two} + {1'b0, s_data.unmeth_two};
        work.cnt_one  = !cfg.side_one_is_beta;
        work.cov_one  = cfg.side_one_is_beta ? !s_data.na_one : (cov_one >= min_cov);
        work.num_one  = s_data.meth_one;
        work.den_one  = cov_one;
        work.beta_one = (s_data.beta_one > BETA_ONE) ? BETA_ONE : s_data.beta_one;
        work.cnt_two  = !cfg.side_two_is_beta;
        work.cov_two  = cfg.side_two_is_beta ? !s_data.na_two : (cov_two >= min_cov);
        work.num_two  = s_data.meth_two;
        work.den_two  = cov_two;
        work.beta_two = (s_data.beta_two > BETA_ONE) ? BETA_ONE : s_data.beta_two;
        work.last     = s_data.last_site;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = q_mem_reg[rd_ptr_reg];

    // Hold classified requests in a two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= work;
        end
    end

endmodule
`default_nettype wire

// ----- sv/mpc_div.sv -----
`default_nettype none
module mpc_div import mpc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic               step,
    input  wire logic [COUNT_W-1:0] num,
    input  wire logic [COV_W-1:0]   den,
    output logic [BETA_W-1:0]       quot
);

    logic [COV_W:0]    rem_reg;
    logic [BETA_W-1:0] quot_reg;
    logic [COV_W:0]    den_ext;
    logic              fits;
    logic [COV_W:0]    rem_sub;

    assign den_ext = {1'b0, den};
    assign fits    = (rem_reg >= den_ext);
    assign rem_sub = fits ? (rem_reg - den_ext) : rem_reg;
    assign quot    = quot_reg;

    // Restoring division, one quotient bit per step, numerator scaled by 2^16
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= {2'b0, num};
            quot_reg <= '0;
        end else if (step) begin
            rem_reg  <= {rem_sub[COV_W-1:0], 1'b0};
            quot_reg <= {quot_reg[BETA_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ----- sv/mpc_back.sv -----
`default_nettype none
module mpc_back import mpc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mpc_cfg_t  cfg,
    input  wire logic      q_valid,
    input  wire mpc_work_t q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output mpc_out_t       m_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EVAL = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic [4:0] MUL_AD   = 5'd0;
    localparam logic [4:0] MUL_XX   = 5'd1;
    localparam logic [4:0] MUL_YY   = 5'd2;
    localparam logic [4:0] MUL_XY   = 5'd3;
    localparam logic [4:0] MUL_LAST = 5'd4;

    state_t      state_reg;
    logic [4:0]  step_reg;
    mpc_work_t   work_reg;
    logic [BETA_W-1:0] quot_one;
    logic [BETA_W-1:0] quot_two;
    logic        div_load;
    logic        div_step;

    logic [BETA_W-1:0] b1_reg, b2_reg, ad_reg;
    logic        uni_reg, set_reg, add_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [CNT_W-1:0] acc_sites_reg, acc_agree_reg;
    logic [SUM_W-1:0] acc_abs_reg, acc_x_reg, acc_y_reg;
    logic [SQ_W-1:0]  acc_sq_reg, acc_xx_reg, acc_yy_reg, acc_xy_reg;

    mpc_out_t    out_reg;
    logic        m_valid_reg;

    logic [BETA_W-1:0] b1, b2, ad;
    logic        uni, add, hit, agree;
    logic signed [BETA_W+1:0] diff, ndiff, eff;
    logic [BETA_W-1:0] op_a, op_b;
    logic        out_free;
    mpc_out_t    out_next;

    assign div_load = (state_reg == S_IDLE) && q_valid;
    assign div_step = (state_reg == S_DIV);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_DONE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    mpc_div u_div_one (
        .aclk (aclk),
        .load (div_load),
        .step (div_step),
        .num  (q_data.num_one),
        .den  (q_data.den_one),
        .quot (quot_one)
    );

    mpc_div u_div_two (
        .aclk (aclk),
        .load (div_load),
        .step (div_step),
        .num  (q_data.num_two),
        .den  (q_data.den_two),
        .quot (quot_two)
    );

    // Resolve betas, coverage and the differential call
    always_comb begin
        b1    = work_reg.cnt_one ? quot_one : work_reg.beta_one;
        b2    = work_reg.cnt_two ? quot_two : work_reg.beta_two;
        uni   = work_reg.cov_one && work_reg.cov_two;
        add   = cfg.summary_mode && uni && (acc_sites_reg < MAX_SITES);
        ad    = (b1 > b2) ? (b1 - b2) : (b2 - b1);
        agree = ((b1 >= cfg.agree_threshold) == (b2 >= cfg.agree_threshold));
        diff  = $signed({2'b00, b1}) - $signed({2'b00, b2});
        ndiff = -diff;
        eff   = {cfg.effect_floor[17], cfg.effect_floor};
        if (cfg.direction == DIR_UP) begin
            hit = (diff > 0) && (diff > eff);
        end else if (cfg.direction == DIR_DOWN) begin
            hit = (diff < 0) && (ndiff > eff);
        end else if (eff <= 0) begin
            hit = (diff != 0);
        end else begin
            hit = (diff > eff) || (ndiff > eff);
        end
    end

    // Select multiplier operands
    always_comb begin
        case (step_reg)
            MUL_AD:  begin op_a = ad_reg; op_b = ad_reg; end
            MUL_XX:  begin op_a = b1_reg; op_b = b1_reg; end
            MUL_YY:  begin op_a = b2_reg; op_b = b2_reg; end
            default: begin op_a = b1_reg; op_b = b2_reg; end
        endcase
    end

    // Form the result from the updated accumulators
    always_comb begin
        out_next              = '0;
        out_next.in_universe  = uni_reg;
        out_next.set_bit      = set_reg;
        out_next.is_last      = work_reg.last;
        if (cfg.summary_mode) begin
            out_next.count_sites  = acc_sites_reg;
            out_next.count_agree  = acc_agree_reg;
            out_next.sum_abs_diff = acc_abs_reg;
            out_next.sum_sq_diff  = acc_sq_reg;
            out_next.sum_x        = acc_x_reg;
            out_next.sum_y        = acc_y_reg;
            out_next.sum_xx       = acc_xx_reg;
            out_next.sum_yy       = acc_yy_reg;
            out_next.sum_xy       = acc_xy_reg;
        end
    end

    // Sequence divide, evaluate, multiply-accumulate and hand-off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
            acc_sites_reg <= '0;
            acc_agree_reg <= '0;
            acc_abs_reg   <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_sq_reg    <= '0;
            acc_xx_reg    <= '0;
            acc_yy_reg    <= '0;
            acc_xy_reg    <= '0;
        end else begin
            // Raise the result on hand-off, drop it once taken
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        step_reg  <= 5'(DIV_STEPS - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= S_EVAL;
                    end else begin
                        step_reg <= step_reg - 5'd1;
                    end
                end
                S_EVAL: begin
                    if (add) begin
                        acc_sites_reg <= acc_sites_reg + CNT_W'(1);
                        if (agree) begin
                            acc_agree_reg <= acc_agree_reg + CNT_W'(1);
                        end
                        acc_abs_reg <= acc_abs_reg + SUM_W'(ad);
                        acc_x_reg   <= acc_x_reg + SUM_W'(b1);
                        acc_y_reg   <= acc_y_reg + SUM_W'(b2);
                    end
                    step_reg  <= MUL_AD;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (add_reg) begin
                        case (step_reg)
                            MUL_XX:   acc_sq_reg <= acc_sq_reg + SQ_W'(prod_reg);
                            MUL_YY:   acc_xx_reg <= acc_xx_reg + SQ_W'(prod_reg);
                            MUL_XY:   acc_yy_reg <= acc_yy_reg + SQ_W'(prod_reg);
                            MUL_LAST: acc_xy_reg <= acc_xy_reg + SQ_W'(prod_reg);
                            default:  ;
                        endcase
                    end
                    if (step_reg == MUL_LAST) begin
                        state_reg <= S_DONE;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg   <= S_IDLE;
                        if (work_reg.last) begin
                            acc_sites_reg <= '0;
                            acc_agree_reg <= '0;
                            acc_abs_reg   <= '0;
                            acc_x_reg     <= '0;
                            acc_y_reg     <= '0;
                            acc_sq_reg    <= '0;
                            acc_xx_reg    <= '0;
                            acc_yy_reg    <= '0;
                            acc_xy_reg    <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (div_load) begin
            work_reg <= q_data;
        end
        if (state_reg == S_EVAL) begin
            b1_reg  <= b1;
            b2_reg  <= b2;
            ad_reg  <= ad;
            uni_reg <= uni;
            add_reg <= add;
            set_reg <= uni && !cfg.summary_mode && hit;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= op_a * op_b;
        end
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/methylation_pair_compare.sv -----
// Each site is accepted into the queue, then passes through load, bit-serial
//   divide, evaluate, multiply-accumulate and hand-off before its result is valid.
// One site is processed at a time: the bit-serial dividers and the single 17x17
//   multiplier, stepping through four products, finish a site before the next is popped.
// Reset: synchronous active-low aresetn clears queue, sequencer, output valid,
//   all accumulators and loads the register defaults.
`default_nettype none
module methylation_pair_compare import mpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [17:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire mpc_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output mpc_out_t         m_data
);

    mpc_cfg_t  cfg_reg;
    logic      q_valid;
    mpc_work_t q_data;
    logic      q_pop;

    // Decode configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.summary_mode     <= 1'b0;
            cfg_reg.direction        <= DIR_UP;
            cfg_reg.cov_floor        <= 17'd1;
            cfg_reg.effect_floor     <= '0;
            cfg_reg.agree_threshold  <= 17'd32768;
            cfg_reg.side_one_is_beta <= 1'b0;
            cfg_reg.side_two_is_beta <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SUMMARY_MODE: cfg_reg.summary_mode     <= cfg_wdata[0];
                CFG_DIRECTION:    cfg_reg.direction        <= cfg_wdata[1:0];
                CFG_COV_FLOOR:    cfg_reg.cov_floor        <= cfg_wdata[16:0];
                CFG_EFFECT_FLOOR: cfg_reg.effect_floor     <= $signed(cfg_wdata);
                CFG_AGREE_THRESH: cfg_reg.agree_threshold  <= cfg_wdata[16:0];
                CFG_SIDE_ONE:     cfg_reg.side_one_is_beta <= cfg_wdata[0];
                CFG_SIDE_TWO:     cfg_reg.side_two_is_beta <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    mpc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    mpc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- sv/mpc_checker.sv -----
`default_nettype none
`include "methylation_pair_compare_assert.svh"
module mpc_checker import mpc_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire mpc_out_t m_data
);

    // A differential call needs both samples covered
    `MPC_ASSERT_IMPL(a_set_uni, m_valid && m_data.set_bit, m_data.in_universe, "set outside")

    // Agreements never outnumber counted sites
    `MPC_ASSERT_IMPL(a_agree_le, m_valid, m_data.count_agree <= m_data.count_sites, "agree")

    // A stalled result holds
    `MPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "hold")

    // No result straight after reset release
    `MPC_ASSERT_IMPL(a_reset_quiet, !$past(aresetn), !m_valid, "valid after reset")

endmodule

bind methylation_pair_compare mpc_checker u_mpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
